/* rtl/core/per_source_flow_anomaly_detector_assert.svh */
// Assertion macros shared by the detector RTL.
`ifndef PER_SOURCE_FLOW_ANOMALY_DETECTOR_ASSERT_SVH
`define PER_SOURCE_FLOW_ANOMALY_DETECTOR_ASSERT_SVH
`ifndef SYNTH
// Checked outside reset.
`define PSFAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PSFAD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PSFAD_ASSERT(lbl, prop, msg)
`define PSFAD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/psfad_pkg.sv */
// ---------------------------------------------------------------------------
// psfad_pkg
// Types, sizes and codes of the per-source flow anomaly detector.
// ---------------------------------------------------------------------------
`default_nettype none
package psfad_pkg;
    localparam int FLOW_ENTRIES  = 1024;
    localparam int PORT_SLOTS    = 16;
    localparam int ALLOW_ENTRIES = 256;

    localparam int FLOW_AW  = $clog2(FLOW_ENTRIES);
    localparam int PORT_SW  = $clog2(PORT_SLOTS);
    localparam int PORT_CW  = $clog2(PORT_SLOTS + 1);
    localparam int ALLOW_AW = $clog2(ALLOW_ENTRIES);
    localparam int ALLOW_FW = $clog2(ALLOW_ENTRIES + 1);

    localparam logic [63:0] WINDOW_RST = 64'd1000000000;
    localparam logic [31:0] CONN_RST   = 32'd50;
    localparam logic [4:0]  PORTL_RST  = 5'd10;
    localparam logic [31:0] BYTES_RST  = 32'd1048576;

    typedef enum logic [1:0] {
        OP_EGRESS  = 2'd0,
        OP_INGRESS = 2'd1,
        OP_ALLOW   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_CONN   = 2'd1,
        CFG_PORTS  = 2'd2,
        CFG_BYTES  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] SIG_RATE    = 2'd0;
    localparam logic [1:0] SIG_SCAN    = 2'd1;
    localparam logic [1:0] SIG_EXFIL   = 2'd2;
    localparam logic [1:0] SIG_LATERAL = 2'd3;
    localparam logic [2:0] SEV_HIGH    = 3'd3;
    localparam logic [2:0] SEV_CRIT    = 3'd4;

    typedef struct packed {
        logic [63:0] window;
        logic [31:0] conn_limit;
        logic [4:0]  port_limit;
        logic [31:0] byte_limit;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [63:0] now;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] port;
        logic [15:0] len;
    } t_item;

    typedef struct packed {
        logic               valid;
        logic [31:0]        key;
        logic [63:0]        wstart;
        logic [31:0]        count;
        logic [PORT_CW-1:0] dports;
        logic [31:0]        bytes;
    } t_flow;

    typedef logic [PORT_SLOTS-1:0][15:0] t_row;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  sev;
        logic [31:0] count;
    } t_res;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  sev;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] port;
        logic [31:0] count;
        logic [63:0] now;
        logic        last;
    } t_out;
endpackage
`default_nettype wire

/* rtl/core/per_source_flow_anomaly_detector.sv */
// ---------------------------------------------------------------------------
// per_source_flow_anomaly_detector
// Per-source flow table with rate, port scan, exfiltration and lateral checks.
// ---------------------------------------------------------------------------
// Flow: IDLE pops an item and reads its flow-table row; egress with non-zero
//   destination and allow inserts search the non-empty allow list entry by
//   entry; EVAL updates the tables; EMIT registers each result beat. The next
//   item is popped only back in IDLE, so the search and RMW set the pace.
// Reset: synchronous; the flow table is swept after reset, during which
//   no input beat is taken (config writes still are).
`default_nettype none
module per_source_flow_anomaly_detector (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [63:0] i_now_ns,
    input  wire logic [31:0] i_source_address,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [15:0] i_packet_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_signal_kind,
    output logic [2:0]       o_severity,
    output logic [31:0]      o_flag_src_ip,
    output logic [31:0]      o_flag_dst_ip,
    output logic [15:0]      o_flag_dst_port,
    output logic [31:0]      o_flag_count,
    output logic [63:0]      o_flag_time_ns,
    output logic             o_last_signal,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import psfad_pkg::*;

    t_item in_item, q_item;
    t_cfg  cfg;
    t_out  res;
    logic  busy, q_valid, pop;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    assign in_item = '{op: t_op'(i_opcode), now: i_now_ns, src: i_source_address,
                       dst: i_dest_address, port: i_dest_port, len: i_packet_length};

    // front: accept, drop opcode three, hold up to two items
    psfad_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(in_item),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_cfg(cfg), .i_busy(busy),
        .o_q_valid(q_valid), .o_q_item(q_item), .i_pop(pop));

    // back: table RMW, allow-list search, result beats
    psfad_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .o_busy(busy),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(res));

    assign o_signal_kind   = res.kind;
    assign o_severity      = res.sev;
    assign o_flag_src_ip   = res.src;
    assign o_flag_dst_ip   = res.dst;
    assign o_flag_dst_port = res.port;
    assign o_flag_count    = res.count;
    assign o_flag_time_ns  = res.now;
    assign o_last_signal   = res.last;
endmodule
`default_nettype wire

/* rtl/core/psfad_ram.sv */
// ---------------------------------------------------------------------------
// psfad_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none
module psfad_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/psfad_front.sv */
// ---------------------------------------------------------------------------
// psfad_front
// Input acceptance, opcode screening, config registers and item queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "per_source_flow_anomaly_detector_assert.svh"
module psfad_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire psfad_pkg::t_item i_item,
    input  wire logic             i_cfg_valid,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [63:0]      i_cfg_data,
    output psfad_pkg::t_cfg       o_cfg,
    input  wire logic             i_busy,
    output logic                  o_q_valid,
    output psfad_pkg::t_item      o_q_item,
    input  wire logic             i_pop
);
    import psfad_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, full;
    t_cfg       r_cfg;

    assign full      = (r_cnt == 2'd2);
    assign o_stall   = i_busy || full;
    // opcode three is taken and dropped here
    assign push      = i_valid && !o_stall && (i_item.op != OP_NONE);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_cfg <= '{window: WINDOW_RST, conn_limit: CONN_RST,
                       port_limit: PORTL_RST, byte_limit: BYTES_RST};
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW: r_cfg.window     <= i_cfg_data;
                    CFG_CONN:   r_cfg.conn_limit <= i_cfg_data[31:0];
                    CFG_PORTS:  r_cfg.port_limit <= i_cfg_data[4:0];
                    CFG_BYTES:  r_cfg.byte_limit <= i_cfg_data[31:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    `PSFAD_ASSERT(a_cnt_bound, (r_cnt != 2'd3), "queue count out of range")
    `PSFAD_ASSERT(a_no_pop_empty, (i_pop |-> r_cnt != 2'd0), "pop from empty queue")
    `PSFAD_ASSERT(a_busy_holds, (i_busy |-> o_stall), "input taken during clear")
endmodule
`default_nettype wire

/* rtl/core/psfad_back.sv */
// ---------------------------------------------------------------------------
// psfad_back
// Flow table update, allow-list search and result emission.
// ---------------------------------------------------------------------------
`default_nettype none
`include "per_source_flow_anomaly_detector_assert.svh"
module psfad_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire psfad_pkg::t_cfg  i_cfg,
    output logic                  o_busy,
    input  wire logic             i_q_valid,
    input  wire psfad_pkg::t_item i_q_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output psfad_pkg::t_out       o_out
);
    import psfad_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SRCH  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state              r_st, n_st;
    t_item               r_item;
    logic [FLOW_AW-1:0]  r_clr;
    logic [ALLOW_AW-1:0] r_aidx, n_aidx;
    logic                r_found, n_found;
    logic [ALLOW_FW-1:0] r_fill;
    t_res                r_res [2], n_res [2];
    logic [1:0]          r_nres, n_nres;
    logic                r_ek;
    logic                r_ovld;
    t_out                r_out;

    // memories
    logic [$bits(t_flow)-1:0]   flow_rdata, flow_wdata;
    logic [$bits(t_row)-1:0]    row_rdata;
    logic [31:0]                allow_rdata;
    logic                       flow_we, row_we, allow_we;
    logic [FLOW_AW-1:0]         flow_waddr;
    logic [ALLOW_AW-1:0]        allow_raddr;
    logic [FLOW_AW-1:0]         q_idx;
    t_flow                      fl, nfl;
    t_row                       row, nrow;

    assign q_idx = i_q_item.src[FLOW_AW-1:0];

    psfad_ram #(.W($bits(t_flow)), .D(FLOW_ENTRIES)) u_flow (
        .i_clk(i_clk), .i_we(flow_we), .i_waddr(flow_waddr), .i_wdata(flow_wdata),
        .i_re(o_pop), .i_raddr(q_idx), .o_rdata(flow_rdata));

    psfad_ram #(.W($bits(t_row)), .D(FLOW_ENTRIES)) u_ports (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(r_item.src[FLOW_AW-1:0]),
        .i_wdata(nrow), .i_re(o_pop), .i_raddr(q_idx), .o_rdata(row_rdata));

    psfad_ram #(.W(32), .D(ALLOW_ENTRIES)) u_allow (
        .i_clk(i_clk), .i_we(allow_we), .i_waddr(r_fill[ALLOW_AW-1:0]),
        .i_wdata(r_item.dst), .i_re(1'b1), .i_raddr(allow_raddr),
        .o_rdata(allow_rdata));

    assign o_busy  = (r_st == ST_CLEAR);
    assign o_pop   = (r_st == ST_IDLE) && i_q_valid;
    assign o_valid = r_ovld;
    assign o_out   = r_out;

    assign fl  = t_flow'(flow_rdata);
    assign row = t_row'(row_rdata);

    // flow evaluation
    logic [63:0]        elapsed;
    logic               hit, in_win, seen, lateral;
    logic [32:0]        bsum;
    logic [31:0]        bsat, cinc;
    logic [PORT_CW-1:0] dinc;

    always_comb begin
        elapsed = r_item.now - fl.wstart;
        hit     = fl.valid && (fl.key == r_item.src);
        in_win  = hit && (elapsed < i_cfg.window);
        bsum    = {1'b0, fl.bytes} + {17'd0, r_item.len};
        bsat    = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
        cinc    = (fl.count == 32'hFFFF_FFFF) ? fl.count : fl.count + 32'd1;
        dinc    = fl.dports + PORT_CW'(1);
        lateral = (r_item.dst != 32'd0) && !r_found;
        seen    = 1'b0;
        for (int i = 0; i < PORT_SLOTS; i++) begin
            if ((PORT_CW'(i) < fl.dports) && (row[i] == r_item.port)) begin
                seen = 1'b1;
            end
        end

        nfl    = fl;
        nrow   = row;
        n_nres = 2'd0;
        n_res  = r_res;
        if (!hit) begin
            nfl.valid  = 1'b1;
            nfl.key    = r_item.src;
            nfl.wstart = r_item.now;
            nfl.count  = 32'd1;
            nfl.dports = PORT_CW'(1);
            nfl.bytes  = (r_item.op == OP_EGRESS) ? {16'd0, r_item.len} : 32'd0;
            nrow[0]    = r_item.port;
        end
        if (r_item.op == OP_EGRESS) begin
            if (lateral) begin
                n_res[n_nres[0]] = '{kind: SIG_LATERAL, sev: SEV_HIGH, count: 32'd1};
                n_nres = n_nres + 2'd1;
            end
            if (in_win) begin
                nfl.bytes = bsat;
                if (bsat > i_cfg.byte_limit) begin
                    n_res[n_nres[0]] = '{kind: SIG_EXFIL, sev: SEV_CRIT, count: bsat};
                    n_nres = n_nres + 2'd1;
                end
            end else if (hit) begin
                nfl.bytes  = {16'd0, r_item.len};
                nfl.wstart = r_item.now;
            end
        end else begin
            if (in_win) begin
                nfl.count = cinc;
                if (cinc > i_cfg.conn_limit) begin
                    n_res[n_nres[0]] = '{kind: SIG_RATE, sev: SEV_HIGH, count: cinc};
                    n_nres = n_nres + 2'd1;
                end
                if (!seen && (fl.dports < PORT_CW'(PORT_SLOTS))) begin
                    nrow[fl.dports[PORT_SW-1:0]] = r_item.port;
                    nfl.dports = dinc;
                    if (32'(dinc) > 32'(i_cfg.port_limit)) begin
                        n_res[n_nres[0]] = '{kind: SIG_SCAN, sev: SEV_CRIT,
                                             count: 32'(dinc)};
                        n_nres = n_nres + 2'd1;
                    end
                end
            end else if (hit) begin
                nfl.count  = 32'd1;
                nfl.dports = PORT_CW'(1);
                nfl.wstart = r_item.now;
                nrow[0]    = r_item.port;
            end
        end
    end

    logic is_pkt, a_last, a_match, out_free;
    assign is_pkt   = (r_item.op != OP_ALLOW);
    assign a_match  = (allow_rdata == r_item.dst);
    assign a_last   = (({1'b0, r_aidx} + ALLOW_FW'(1)) == r_fill);
    assign out_free = !r_ovld || !i_stall;

    always_comb begin
        allow_raddr = '0;
        if (r_st == ST_SRCH) begin
            allow_raddr = r_aidx + ALLOW_AW'(1);
        end
        flow_we    = 1'b0;
        row_we     = 1'b0;
        allow_we   = 1'b0;
        flow_waddr = r_item.src[FLOW_AW-1:0];
        flow_wdata = nfl;
        if (r_st == ST_CLEAR) begin
            flow_we    = 1'b1;
            flow_waddr = r_clr;
            flow_wdata = '0;
        end else if (r_st == ST_EVAL) begin
            flow_we  = is_pkt;
            row_we   = is_pkt;
            allow_we = !is_pkt && !r_found && (r_fill < ALLOW_FW'(ALLOW_ENTRIES));
        end
    end

    always_comb begin
        n_st    = r_st;
        n_aidx  = r_aidx;
        n_found = r_found;
        unique case (r_st)
            ST_CLEAR: begin
                if (r_clr == FLOW_AW'(FLOW_ENTRIES - 1)) begin
                    n_st = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_aidx  = '0;
                n_found = 1'b0;
                if (i_q_valid) begin
                    // search only when there is something to look up
                    if ((r_fill != '0) && ((i_q_item.op == OP_ALLOW)
                                           || ((i_q_item.op == OP_EGRESS)
                                               && (i_q_item.dst != 32'd0)))) begin
                        n_st = ST_SRCH;
                    end else begin
                        n_st = ST_EVAL;
                    end
                end
            end
            ST_SRCH: begin
                if (a_match) begin
                    n_found = 1'b1;
                    n_st    = ST_EVAL;
                end else if (a_last) begin
                    n_st = ST_EVAL;
                end else begin
                    n_aidx = r_aidx + ALLOW_AW'(1);
                end
            end
            ST_EVAL: begin
                n_st = (is_pkt && (n_nres != 2'd0)) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free && ({1'b0, r_ek} + 2'd1 == r_nres)) begin
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLEAR;
            r_clr  <= '0;
            r_fill <= '0;
            r_nres <= 2'd0;
            r_ek   <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) begin
                r_clr <= r_clr + FLOW_AW'(1);
            end
            if (allow_we) begin
                r_fill <= r_fill + ALLOW_FW'(1);
            end
            if (r_st == ST_EVAL) begin
                r_nres <= is_pkt ? n_nres : 2'd0;
                r_ek   <= 1'b0;
            end else if (r_st == ST_EMIT && out_free) begin
                r_ek <= ~r_ek;
            end
            if (r_st == ST_EMIT && out_free) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_aidx  <= n_aidx;
        r_found <= n_found;
        if (o_pop) begin
            r_item <= i_q_item;
        end
        if (r_st == ST_EVAL) begin
            r_res <= n_res;
        end
        if (r_st == ST_EMIT && out_free) begin
            r_out <= '{kind: r_res[r_ek].kind, sev: r_res[r_ek].sev,
                       src: r_item.src, dst: r_item.dst, port: r_item.port,
                       count: r_res[r_ek].count, now: r_item.now,
                       last: ({1'b0, r_ek} + 2'd1 == r_nres)};
        end
    end

    `PSFAD_ASSERT(a_fill_bound, (r_fill <= ALLOW_FW'(ALLOW_ENTRIES)), "allow fill overflow")
    `PSFAD_ASSERT(a_emit_has_res, (r_st == ST_EMIT |-> r_nres != 2'd0), "emit with no result")
    `PSFAD_ASSERT(a_no_pop_clear, (r_st == ST_CLEAR |-> !o_pop), "pop during clear")
    `PSFAD_ASSERT_ALWAYS(a_rst_clear, (!i_rst_n |=> r_st == ST_CLEAR), "reset did not clear")
endmodule
`default_nettype wire

/* tb/per_source_flow_anomaly_detector_tb.sv */
// ---------------------------------------------------------------------------
// per_source_flow_anomaly_detector_tb
// Drives packets, allow inserts and register writes into the detector, keeps
// a shadow flow table and allow list, and checks every signal beat in order.
// ---------------------------------------------------------------------------
`default_nettype none
module per_source_flow_anomaly_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psfad_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 1000;  // three worst allow-list searches plus pipeline

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [63:0] i_now_ns = '0;
    logic [31:0] i_source_address = '0;
    logic [31:0] i_dest_address = '0;
    logic [15:0] i_dest_port = '0;
    logic [15:0] i_packet_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_signal_kind;
    logic [2:0]  o_severity;
    logic [31:0] o_flag_src_ip;
    logic [31:0] o_flag_dst_ip;
    logic [15:0] o_flag_dst_port;
    logic [31:0] o_flag_count;
    logic [63:0] o_flag_time_ns;
    logic        o_last_signal;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    per_source_flow_anomaly_detector u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block's registers and tables
    t_cfg        cfg_shadow;
    bit          flow_live   [FLOW_ENTRIES];
    logic [31:0] flow_tag    [FLOW_ENTRIES];
    logic [63:0] flow_wstart [FLOW_ENTRIES];
    logic [31:0] flow_conns  [FLOW_ENTRIES];
    int          flow_nports [FLOW_ENTRIES];
    logic [15:0] flow_ports  [FLOW_ENTRIES][PORT_SLOTS];
    logic [31:0] flow_bytes  [FLOW_ENTRIES];
    logic [31:0] allow_list  [$];

    t_out  pending_signals[$];
    int    error_count = 0;
    int    cycle_count = 0;
    logic [63:0] clock_ns = 64'd5000;  // running packet timestamp

    // Each signal beat is compared with the oldest pending one.
    always @(posedge i_clk) begin
        t_out exp_sig;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_signals.size() == 0) begin
                $error("signal beat with nothing pending: kind %0d src %h",
                       o_signal_kind, o_flag_src_ip);
                error_count++;
            end else begin
                exp_sig = pending_signals.pop_front();
                if (o_signal_kind !== exp_sig.kind) begin
                    $error("signal_kind exp %0d got %0d", exp_sig.kind, o_signal_kind);
                    error_count++;
                end
                if (o_severity !== exp_sig.sev) begin
                    $error("severity exp %0d got %0d", exp_sig.sev, o_severity);
                    error_count++;
                end
                if (o_flag_src_ip !== exp_sig.src) begin
                    $error("flag_src_ip exp %h got %h", exp_sig.src, o_flag_src_ip);
                    error_count++;
                end
                if (o_flag_dst_ip !== exp_sig.dst) begin
                    $error("flag_dst_ip exp %h got %h", exp_sig.dst, o_flag_dst_ip);
                    error_count++;
                end
                if (o_flag_dst_port !== exp_sig.port) begin
                    $error("flag_dst_port exp %h got %h", exp_sig.port, o_flag_dst_port);
                    error_count++;
                end
                if (o_flag_count !== exp_sig.count) begin
                    $error("flag_count exp %0d got %0d", exp_sig.count, o_flag_count);
                    error_count++;
                end
                if (o_flag_time_ns !== exp_sig.now) begin
                    $error("flag_time_ns exp %h got %h", exp_sig.now, o_flag_time_ns);
                    error_count++;
                end
                if (o_last_signal !== exp_sig.last) begin
                    $error("last_signal exp %0d got %0d", exp_sig.last, o_last_signal);
                    error_count++;
                end
            end
        end
    end

    // Output-side stall is raised for random stretches, sometimes none, with occasional quiet spells.
    initial begin
        int gap;
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (quiet > 0) begin
                quiet--;
                i_stall <= 1'b0;
            end else begin
                if ($urandom_range(0, 40) == 0) quiet = $urandom_range(20, 80);
                gap = $urandom_range(0, 8);
                if (gap > 0 && $urandom_range(0, 1)) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    function automatic bit is_allowed(logic [31:0] addr);
        foreach (allow_list[k]) if (allow_list[k] == addr) return 1'b1;
        return 1'b0;
    endfunction

    // Works out the signals of one packet and updates the shadow tables.
    function automatic void predict_signals(t_item it);
        int          idx;
        bit          hit;
        bit          in_win;
        bit          seen;
        int          d;
        int          made;
        logic [32:0] sum;
        logic [31:0] c;
        t_out        sig;
        made = 0;
        idx = it.src % FLOW_ENTRIES;
        if (it.op == OP_ALLOW) begin
            if (!is_allowed(it.dst) && allow_list.size() < ALLOW_ENTRIES)
                allow_list.push_back(it.dst);
            return;
        end
        if (it.op == OP_NONE) return;
        hit = flow_live[idx] && flow_tag[idx] == it.src;
        in_win = hit && ((it.now - flow_wstart[idx]) < cfg_shadow.window);
        sig.src = it.src;
        sig.dst = it.dst;
        sig.port = it.port;
        sig.now = it.now;
        sig.last = 1'b1;
        if (it.op == OP_EGRESS) begin
            if (it.dst != 0 && !is_allowed(it.dst)) begin
                sig.kind = SIG_LATERAL;
                sig.sev = SEV_HIGH;
                sig.count = 32'd1;
                pending_signals.push_back(sig);
                made++;
            end
        end
        if (!hit) begin
            flow_live[idx] = 1'b1;
            flow_tag[idx] = it.src;
            flow_wstart[idx] = it.now;
            flow_conns[idx] = 32'd1;
            flow_nports[idx] = 1;
            flow_ports[idx][0] = it.port;
            flow_bytes[idx] = (it.op == OP_EGRESS) ? {16'd0, it.len} : 32'd0;
        end else if (it.op == OP_EGRESS) begin
            if (in_win) begin
                sum = {1'b0, flow_bytes[idx]} + it.len;
                flow_bytes[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (flow_bytes[idx] > cfg_shadow.byte_limit) begin
                    sig.kind = SIG_EXFIL;
                    sig.sev = SEV_CRIT;
                    sig.count = flow_bytes[idx];
                    if (made > 0) pending_signals[$].last = 1'b0;
                    pending_signals.push_back(sig);
                end
            end else begin
                flow_bytes[idx] = {16'd0, it.len};
                flow_wstart[idx] = it.now;
            end
        end else if (in_win) begin
            c = flow_conns[idx];
            if (c != 32'hFFFF_FFFF) c++;
            flow_conns[idx] = c;
            if (c > cfg_shadow.conn_limit) begin
                sig.kind = SIG_RATE;
                sig.sev = SEV_HIGH;
                sig.count = c;
                pending_signals.push_back(sig);
                made++;
            end
            d = flow_nports[idx];
            seen = 1'b0;
            for (int k = 0; k < d; k++) if (flow_ports[idx][k] == it.port) seen = 1'b1;
            if (!seen && d < PORT_SLOTS) begin
                flow_ports[idx][d] = it.port;
                d++;
                flow_nports[idx] = d;
                if (d > cfg_shadow.port_limit) begin
                    sig.kind = SIG_SCAN;
                    sig.sev = SEV_CRIT;
                    sig.count = d;
                    if (made > 0) pending_signals[$].last = 1'b0;
                    pending_signals.push_back(sig);
                end
            end
        end else begin
            flow_conns[idx] = 32'd1;
            flow_nports[idx] = 1;
            flow_wstart[idx] = it.now;
            flow_ports[idx][0] = it.port;
        end
    endfunction

    // One input beat, after a random hold-off; valid stays up for a back-to-back beat.
    task automatic send_item(t_op op, logic [63:0] now, logic [31:0] src,
                             logic [31:0] dst, logic [15:0] port, logic [15:0] len);
        t_item it;
        int    gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it = '{op: op, now: now, src: src, dst: dst, port: port, len: len};
        i_valid <= 1'b1;
        i_opcode <= op;
        i_now_ns <= now;
        i_source_address <= src;
        i_dest_address <= dst;
        i_dest_port <= port;
        i_packet_length <= len;
        do @(posedge i_clk); while (o_stall);
        predict_signals(it);
    endtask

    // Waits for every pending signal, then lets allow-list searches finish.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_signals.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WINDOW: cfg_shadow.window = value;
            CFG_CONN:   cfg_shadow.conn_limit = value[31:0];
            CFG_PORTS:  cfg_shadow.port_limit = value[4:0];
            default:    cfg_shadow.byte_limit = value[31:0];
        endcase
    endtask

    task automatic set_config(logic [63:0] win, logic [31:0] conn,
                              logic [4:0] ports, logic [31:0] bytes);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_CONN, conn);
        write_reg(CFG_PORTS, ports);
        write_reg(CFG_BYTES, bytes);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed: reset limits, field extremes, each op, window edges.
    task automatic test_directed();
        // new flow, then in-window egress crossing the byte limit
        send_item(OP_EGRESS, 64'd100, 32'h0A00_0001, 32'h0, 16'd80, 16'hFFFF);
        repeat (16) send_item(OP_EGRESS, 64'd200, 32'h0A00_0001, 32'h0, 16'd80, 16'hFFFF);
        // lateral movement, then allow it, then duplicate insert
        send_item(OP_EGRESS, 64'd300, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_item(OP_ALLOW, 64'd0, 32'h0, 32'hFFFF_FFFF, 16'd0, 16'd0);
        send_item(OP_ALLOW, 64'd0, 32'h0, 32'hFFFF_FFFF, 16'd0, 16'd0);
        send_item(OP_EGRESS, 64'd400, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd10);
        // ignored opcode
        send_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 32'h5, 16'd1, 16'd1);
        // time wrap: window start near the top, now small
        send_item(OP_INGRESS, 64'hFFFF_FFFF_FFFF_FF00, 32'h0000_0400, 32'h1, 16'd1, 16'd0);
        send_item(OP_INGRESS, 64'h10, 32'h0000_0400, 32'h1, 16'd2, 16'd0);
        // window expiry restarts
        send_item(OP_INGRESS, 64'd5_000_000_000, 32'h0000_0400, 32'h1, 16'd3, 16'd0);
        send_item(OP_EGRESS, 64'd9_000_000_000, 32'h0A00_0001, 32'h0, 16'd3, 16'd7);
        // tag mismatch on the same index
        send_item(OP_INGRESS, 64'd10, 32'h0000_0000, 32'h1, 16'd4, 16'd0);
        wait_idle();
    endtask

    // Ingress with tight limits: rate and scan, full port table.
    task automatic test_scan_rate();
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 5'd2, 32'd0);
        for (int k = 0; k < 20; k++)
            send_item(OP_INGRESS, clock_ns + k, 32'hC0A8_0105, 32'h2, 16'(k % 18), 16'd0);
        clock_ns += 100;
        wait_idle();
        set_config(64'd0, 32'd0, 5'd0, 32'd0);
        send_item(OP_INGRESS, clock_ns, 32'hC0A8_0105, 32'h2, 16'd9, 16'd0);
        send_item(OP_EGRESS, clock_ns, 32'hC0A8_0105, 32'h0, 16'd9, 16'd5);
        wait_idle();
    endtask

    // Random flows over a small set of sources so entries get reused.
    task automatic test_random(int n_items, logic [63:0] win);
        logic [31:0] src;
        logic [31:0] dst;
        int          pick;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 19);
            src = (pick < 16) ? {22'h2A0B1 ^ 22'(pick), 10'(pick * 37)} : $urandom;
            if ($urandom_range(0, 3) == 0) dst = 32'h0;
            else if ($urandom_range(0, 1)) dst = 32'hAC10_0000 | $urandom_range(0, 7);
            else dst = $urandom;
            clock_ns += $urandom_range(0, 3) == 0 ? win : 64'($urandom_range(0, 300));
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(OP_EGRESS, clock_ns, src, dst, 16'($urandom), 16'($urandom));
            else if (pick < 90)
                send_item(OP_INGRESS, clock_ns, src, dst,
                          $urandom_range(0, 1) ? 16'($urandom_range(0, 24)) : 16'($urandom),
                          16'($urandom));
            else if (pick < 97)
                send_item(OP_ALLOW, 64'($urandom) << 32 | 64'($urandom), $urandom,
                          dst, 16'($urandom), 16'($urandom));
            else
                send_item(OP_NONE, {$urandom, $urandom}, $urandom, $urandom,
                          16'($urandom), 16'($urandom));
        end
        wait_idle();
    endtask

    // Fill the allow list past its capacity.
    task automatic test_allow_fill();
        for (int k = 0; k < ALLOW_ENTRIES + 4; k++)
            send_item(OP_ALLOW, 64'd0, 32'h0, 32'h5000_0000 + k, 16'd0, 16'd0);
        send_item(OP_EGRESS, clock_ns, 32'h7, 32'h5000_0000 + ALLOW_ENTRIES + 1, 16'd1, 16'd1);
        send_item(OP_EGRESS, clock_ns, 32'h7, 32'h5000_0000 + ALLOW_ENTRIES - 1, 16'd1, 16'd1);
        wait_idle();
    endtask

    initial begin
        cfg_shadow = '{window: WINDOW_RST, conn_limit: CONN_RST,
                       port_limit: PORTL_RST, byte_limit: BYTES_RST};
        foreach (flow_live[k]) flow_live[k] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_scan_rate();
        set_config(64'd1000, 32'd4, 5'd3, 32'd100000);
        test_random(100, 64'd1000);
        set_config(64'd1, 32'hFFFF_FFFF, 5'd16, 32'hFFFF_FFFF);
        test_random(40, 64'd1);
        set_config(64'd500, 32'd2, 5'd1, 32'd30000);
        test_random(80, 64'd500);
        test_allow_fill();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* per_source_flow_anomaly_detector.f */
+incdir+rtl/core
rtl/core/psfad_pkg.sv
rtl/core/psfad_ram.sv
rtl/core/psfad_front.sv
rtl/core/psfad_back.sv
rtl/core/per_source_flow_anomaly_detector.sv
tb/per_source_flow_anomaly_detector_tb.sv
